>>> sv/kcnf_pkg.sv
// Shared types and constants for the key color nearest fill block.
`timescale 1ns / 1ps

package kcnf_pkg;

  localparam int PIX_W   = 32;
  localparam int COORD_W = 8;
  localparam int SIDE_W  = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W   = 32;

  typedef logic [PIX_W-1:0]   pixel_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [1:0]         status_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam status_t ST_KEPT      = 2'd0;
  localparam status_t ST_REPLACED  = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIDE = 1'd1;

  localparam pixel_t            KEY_COLOR_RESET  = 32'h0000_00FF;
  localparam logic [SIDE_W-1:0] FRAME_SIDE_RESET = 9'd256;

endpackage

>>> sv/kcnf_if.sv
// Valid/ready channel interfaces for request items and result items.
`timescale 1ns / 1ps

interface kcnf_item_if;
  logic                  valid;
  logic                  ready;
  logic                  op;
  kcnf_pkg::coord_t      x_pos;
  kcnf_pkg::coord_t      y_pos;
  kcnf_pkg::pixel_t      pixel_value;

  modport source (output valid, op, x_pos, y_pos, pixel_value, input ready);
  modport sink   (input valid, op, x_pos, y_pos, pixel_value, output ready);
endinterface

interface kcnf_result_if;
  logic                  valid;
  logic                  ready;
  kcnf_pkg::pixel_t      out_pixel;
  kcnf_pkg::status_t     status;

  modport source (output valid, out_pixel, status, input ready);
  modport sink   (input valid, out_pixel, status, output ready);
endinterface

>>> sv/key_color_nearest_fill.sv
// Top level of the key color nearest fill block: frame store and ring search sequencer.
//
// Usage: configure key_color (index 0) and frame_side (index 1) on the plain write
// port while the block is idle. Items arrive on the item channel. A write item
// (op 0) stores pixel_value at (x_pos, y_pos) in the cycle of its transfer and
// returns nothing. A query item (op 1) returns one result on the result channel:
// the stored pixel if it is not the key color, else the nearest non-key pixel by
// square rings clipped to the frame (column first, then row within the column).
// Sequence: a write is stored at its transfer. A query outside the frame goes
// straight to its result; an in-frame query reads the center at transfer. A search
// then takes per visited ring a setup step (RING), a step per column (COL) and
// a read per cell (SCAN), since the single frame-store port reads one ring
// cell per cycle; a hit is compared after its read, then moved to the output.
// One item is worked on at a time; the item channel is ready in idle even while a
// finished result still waits in the output register, so writes keep flowing
// under a stalled receiver. A query that ends while the output is full holds.
// Reset clears control state and loads the register defaults; the frame store is
// not cleared, so a query must only touch positions already written.
`timescale 1ns / 1ps

module key_color_nearest_fill #(
  parameter int MAX_SIDE = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [kcnf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kcnf_pkg::CFG_W-1:0]        cfg_data,
  kcnf_item_if.sink                         item,
  kcnf_result_if.source                     result
);

  import kcnf_pkg::*;

  localparam int XW    = $clog2(MAX_SIDE);         // coordinate bits inside the store
  localparam int EW    = XW + 1;                   // room for sums and the side itself
  localparam int SDW   = $clog2(MAX_SIDE + 1);
  localparam int CW    = (EW > COORD_W) ? EW : COORD_W;
  localparam int AW    = 2 * XW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [2:0] {
    IDLE, CENTER, RING, COL, SCAN, FINISH, EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  pixel_t            key_color;
  logic [SIDE_W-1:0] frame_side;

  // Query and search registers.
  logic [XW-1:0] qx, qy, r;
  logic [XW-1:0] a, b, a_hi, b_lo, b_hi;
  logic [XW-1:0] xl, xr, yt, yb;
  logic          left_in, right_in, top_in, bot_in;
  logic          edge_col, on_top;
  logic          rd_pend;
  pixel_t        res_pixel;
  status_t       res_status;

  // Output register.
  logic          out_valid;
  pixel_t        out_pixel;
  status_t       out_status;

  // Frame store port.
  logic          mem_en, mem_we;
  logic [AW-1:0] mem_addr;
  pixel_t        mem_rdata;

  // Derived values.
  logic [SDW-1:0] side_eff;
  logic [EW-1:0]  smax;
  logic [CW-1:0]  xe, ye;
  logic           in_store, in_frame, item_xfer;
  logic [EW-1:0]  xlv, xrv, ytv, ybv;
  logic           left_c, right_c, top_c, bot_c;
  logic           col_edge, col_last, ring_last, hit;
  logic           emit_go;

  always_comb begin
    int unsigned fs;
    fs = 32'(frame_side);
    if (fs == 0) begin
      side_eff = SDW'(1);
    end else if (fs > MAX_SIDE) begin
      side_eff = SDW'(MAX_SIDE);
    end else begin
      side_eff = SDW'(fs);
    end
  end

  assign smax      = EW'(side_eff) - EW'(1);
  assign xe        = CW'(item.x_pos);
  assign ye        = CW'(item.y_pos);
  assign in_store  = (xe < CW'(MAX_SIDE)) && (ye < CW'(MAX_SIDE));
  assign in_frame  = (xe < CW'(side_eff)) && (ye < CW'(side_eff));
  assign item_xfer = item.valid && item.ready;
  assign item.ready = (state == IDLE);

  // Ring bounds for the current radius, clipped against the frame.
  assign xlv     = {1'b0, qx} - {1'b0, r};
  assign xrv     = {1'b0, qx} + {1'b0, r};
  assign ytv     = {1'b0, qy} - {1'b0, r};
  assign ybv     = {1'b0, qy} + {1'b0, r};
  assign left_c  = (r <= qx);
  assign right_c = (xrv <= smax);
  assign top_c   = (r <= qy);
  assign bot_c   = (ybv <= smax);

  assign col_edge  = (left_in && (a == xl)) || (right_in && (a == xr));
  assign col_last  = (a == a_hi);
  assign ring_last = ({1'b0, r} == smax);
  assign hit       = rd_pend && (mem_rdata != key_color);

  // A finished result moves into the output register when that register is free.
  assign emit_go   = (state == EMIT) && (!out_valid || result.ready);

  // Frame store port: writes and the center read at transfer, ring reads in scan.
  always_comb begin
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = {ye[XW-1:0], xe[XW-1:0]};
    if (state == IDLE) begin
      if (item_xfer && item.op == OP_WRITE && in_store) begin
        mem_en = 1'b1;
        mem_we = 1'b1;
      end else if (item_xfer && item.op == OP_QUERY && in_frame) begin
        mem_en = 1'b1;
      end
    end else if (state == SCAN) begin
      mem_en   = 1'b1;
      mem_addr = {b, a};
    end
  end

  kcnf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (item.pixel_value),
    .rdata (mem_rdata)
  );

  assign result.valid     = out_valid;
  assign result.out_pixel = out_pixel;
  assign result.status    = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
      key_color  <= KEY_COLOR_RESET;
      frame_side <= FRAME_SIDE_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_COLOR:  key_color  <= cfg_data;
          REG_FRAME_SIDE: frame_side <= cfg_data[SIDE_W-1:0];
          default: ;
        endcase
      end

      // Load a finished result, else drop the output once the receiver takes it.
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      rd_pend <= (state == SCAN) && !hit;

      if (hit) begin
        // An earlier read in scan order always wins; discard later reads.
        res_pixel  <= mem_rdata;
        res_status <= ST_REPLACED;
        state      <= EMIT;
      end else begin
        unique case (state)
          IDLE: begin
            if (item_xfer && item.op == OP_QUERY) begin
              qx <= xe[XW-1:0];
              qy <= ye[XW-1:0];
              if (in_frame) begin
                state <= CENTER;
              end else begin
                res_pixel  <= '0;
                res_status <= ST_NOT_FOUND;
                state      <= EMIT;
              end
            end
          end
          CENTER: begin
            if (mem_rdata != key_color) begin
              res_pixel  <= mem_rdata;
              res_status <= ST_KEPT;
              state      <= EMIT;
            end else if (smax == '0) begin
              state <= FINISH;
            end else begin
              r     <= XW'(1);
              state <= RING;
            end
          end
          RING: begin
            left_in  <= left_c;
            right_in <= right_c;
            top_in   <= top_c;
            bot_in   <= bot_c;
            xl       <= xlv[XW-1:0];
            xr       <= xrv[XW-1:0];
            yt       <= ytv[XW-1:0];
            yb       <= ybv[XW-1:0];
            a        <= left_c  ? xlv[XW-1:0] : '0;
            a_hi     <= right_c ? xrv[XW-1:0] : smax[XW-1:0];
            b_lo     <= top_c   ? ytv[XW-1:0] : '0;
            b_hi     <= bot_c   ? ybv[XW-1:0] : smax[XW-1:0];
            // An empty ring means every larger ring is empty too.
            if (!(left_c || right_c || top_c || bot_c)) begin
              state <= FINISH;
            end else begin
              state <= COL;
            end
          end
          COL: begin
            edge_col <= col_edge;
            if (col_edge) begin
              b     <= b_lo;
              state <= SCAN;
            end else if (top_in) begin
              b      <= yt;
              on_top <= 1'b1;
              state  <= SCAN;
            end else if (bot_in) begin
              b      <= yb;
              on_top <= 1'b0;
              state  <= SCAN;
            end else if (!col_last) begin
              a <= a + XW'(1);
            end else if (ring_last) begin
              state <= FINISH;
            end else begin
              r     <= r + XW'(1);
              state <= RING;
            end
          end
          SCAN: begin
            if (edge_col && b != b_hi) begin
              b <= b + XW'(1);
            end else if (!edge_col && on_top && bot_in) begin
              b      <= yb;
              on_top <= 1'b0;
            end else if (!col_last) begin
              a     <= a + XW'(1);
              state <= COL;
            end else if (ring_last) begin
              state <= FINISH;
            end else begin
              r     <= r + XW'(1);
              state <= RING;
            end
          end
          FINISH: begin
            // Wait out the last read before reporting no match.
            if (!rd_pend) begin
              res_pixel  <= '0;
              res_status <= ST_NOT_FOUND;
              state      <= EMIT;
            end
          end
          EMIT: begin
            if (emit_go) begin
              out_pixel  <= res_pixel;
              out_status <= res_status;
              state      <= IDLE;
            end
          end
          default: state <= IDLE;
        endcase
      end
    end
  end

  // Ring reads stay inside the frame in use.
  a_scan_in_frame: assert property (@(posedge clk) disable iff (rst)
    state == SCAN |-> ({1'b0, a} <= smax) && ({1'b0, b} <= smax))
    else $error("ring read outside the frame");

  // A pending compare comes only from a ring read in the previous cycle.
  a_pend_from_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state == SCAN))
    else $error("pending compare without a ring read");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_NOT_FOUND |-> result.out_pixel == '0)
    else $error("not-found result carries a pixel");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.status == ST_KEPT || result.status == ST_REPLACED ||
                     result.status == ST_NOT_FOUND)
    else $error("undefined status code");

  a_no_key_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && out_status != ST_NOT_FOUND |-> out_pixel != key_color)
    else $error("key color returned as a result pixel");

endmodule

>>> sv/kcnf_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module kcnf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds while the port is not enabled.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
